@@ src/annexb_nal_unit_splitter_assert.svh @@
// Assertion macros for the Annex B unit splitter.
// Both macros sample on the rising edge of clk and are off while arst_n is low.
`ifndef ANNEXB_NAL_UNIT_SPLITTER_ASSERT_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every edge.
`define ANXS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be seen.
`define ANXS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ANXS_ASSERT(lbl, prop, msg)
`define ANXS_NEVER(lbl, cond, msg)

`endif

`endif

@@ src/anxs_pkg.sv @@
package anxs_pkg;

	// Offsets and lengths saturate at this width.
	localparam int OFFSET_BITS = 24;
	// A byte position holds up to 2^OFFSET_BITS, so it needs one more bit.
	localparam int POS_W = OFFSET_BITS + 1;
	// Offset and length fields on the result port.
	localparam int FIELD_W = 24;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [POS_W:0] posx_t;

	localparam posx_t OFF_MAX = posx_t'((64'd1 << OFFSET_BITS) - 64'd1);
	localparam pos_t POS_CAP = pos_t'(64'd1 << OFFSET_BITS);

	// Result queue depth; one item can add up to three results.
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int LVL_W = PTR_W + 1;
	localparam int SLOTS = 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CODEC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNITS = 1'd1;
	localparam int CFG_DATA_W = 8;

	// Unit type codes.
	typedef logic [2:0] utype_t;
	localparam utype_t UT_UNKNOWN = 3'd0;
	localparam utype_t UT_VPS = 3'd1;
	localparam utype_t UT_SPS = 3'd2;
	localparam utype_t UT_PPS = 3'd3;
	localparam utype_t UT_IFRAME = 3'd4;
	localparam utype_t UT_PFRAME = 3'd5;

	// Record kinds.
	localparam logic REC_UNIT = 1'b0;
	localparam logic REC_SUMMARY = 1'b1;

	// Start code tail byte and per-codec type values.
	localparam logic [7:0] SC_LAST = 8'h01;
	localparam logic [4:0] H264_SPS = 5'h07;
	localparam logic [4:0] H264_PPS = 5'h08;
	localparam logic [4:0] H264_IDR = 5'h05;
	localparam logic [4:0] H264_NON_IDR = 5'h01;
	localparam logic [5:0] H265_VPS = 6'h20;
	localparam logic [5:0] H265_SPS = 6'h21;
	localparam logic [5:0] H265_PPS = 6'h22;
	localparam logic [5:0] H265_IDR = 6'h13;
	localparam logic [5:0] H265_TRAIL = 6'h01;

	typedef struct packed {
		logic record_kind;
		logic [7:0] unit_index;
		utype_t unit_type;
		logic first_of_type;
		logic [FIELD_W-1:0] start_offset;
		logic [FIELD_W-1:0] length_with_code;
		logic [FIELD_W-1:0] length_without_code;
		logic [7:0] unit_count;
		logic [4:0] types_present;
		logic last_result;
	} rec_t;

	// Results of one item, in delivery order; a slot is pushed when its valid bit is set.
	typedef struct packed {
		logic [SLOTS-1:0] vld;
		rec_t [SLOTS-1:0] rec;
	} push_t;

	// Type of the unit whose first payload byte is b.
	function automatic utype_t classify(logic [7:0] b, logic is_h264);
		utype_t t;
		t = UT_UNKNOWN;
		if (is_h264) begin
			unique case (b[4:0])
				H264_SPS: t = UT_SPS;
				H264_PPS: t = UT_PPS;
				H264_IDR: t = UT_IFRAME;
				H264_NON_IDR: t = UT_PFRAME;
				default: t = UT_UNKNOWN;
			endcase
		end else begin
			unique case (b[6:1])
				H265_VPS: t = UT_VPS;
				H265_SPS: t = UT_SPS;
				H265_PPS: t = UT_PPS;
				H265_IDR: t = UT_IFRAME;
				H265_TRAIL: t = UT_PFRAME;
				default: t = UT_UNKNOWN;
			endcase
		end
		return t;
	endfunction

	// Saturate at the offset limit, then fit the field.
	function automatic logic [FIELD_W-1:0] sat_field(posx_t v);
		posx_t s;
		logic [63:0] w;
		s = (v > OFF_MAX) ? OFF_MAX : v;
		w = 64'(s);
		return w[FIELD_W-1:0];
	endfunction

	// Record of a unit whose payload starts at off and whose body ends at end_pos.
	function automatic rec_t unit_rec(pos_t off, pos_t end_pos, logic [7:0] idx,
			utype_t t, logic first);
		pos_t body;
		pos_t start;
		posx_t lw;
		rec_t r;
		body = (end_pos >= off) ? (end_pos - off) : '0;
		start = (off >= pos_t'(4)) ? (off - pos_t'(4)) : '0;
		lw = {1'b0, body} + posx_t'(4);
		r = '0;
		r.record_kind = REC_UNIT;
		r.unit_index = idx;
		r.unit_type = t;
		r.first_of_type = first;
		r.start_offset = sat_field({1'b0, start});
		r.length_with_code = sat_field(lw);
		r.length_without_code = sat_field({1'b0, body});
		return r;
	endfunction

endpackage

@@ src/anxs_core.sv @@
module anxs_core
	import anxs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic step,
	input logic [7:0] byte_s1,
	input logic last_s1,
	output push_t push
);

	logic codec_is_h264_q;
	logic [7:0] max_units_q;

	pos_t pos_q;
	logic [23:0] recent_q;
	logic pending_q;
	logic stopped_q;
	logic [7:0] units_q;
	pos_t open_off_q;
	utype_t open_type_q;
	logic open_first_q;
	logic [4:0] seen_q;

	utype_t t_new;
	logic take;
	logic set_pending;
	logic [4:0] type_bit;
	pos_t open_off_d;
	utype_t open_type_d;
	logic open_first_d;
	logic [4:0] seen_d;
	logic [7:0] units_d;
	pos_t prev_end;
	posx_t pos_inc;
	pos_t last_end;
	rec_t sum_rec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_is_h264_q <= 1'b1;
			max_units_q <= 8'd16;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CODEC: codec_is_h264_q <= cfg_data[0];
				CFG_MAX_UNITS: max_units_q <= cfg_data;
			endcase
		end
	end

	// Next state of the open unit when a start code's payload byte arrives.
	always_comb begin
		t_new = classify(byte_s1, codec_is_h264_q);
		take = pending_q && (units_q < max_units_q);
		type_bit = (t_new != UT_UNKNOWN) ? (5'd1 << (t_new - utype_t'(1))) : 5'd0;
		open_off_d = open_off_q;
		open_type_d = open_type_q;
		open_first_d = open_first_q;
		seen_d = seen_q;
		units_d = units_q;
		if (take) begin
			open_off_d = pos_q;
			open_type_d = t_new;
			open_first_d = (t_new != UT_UNKNOWN) && ((seen_q & type_bit) == 5'd0);
			seen_d = seen_q | type_bit;
			units_d = units_q + 8'd1;
		end
		set_pending = !pending_q && !stopped_q && (byte_s1 == SC_LAST) && (recent_q == 24'd0)
			&& (pos_q >= pos_t'(3)) && !last_s1;
	end

	// Results: the unit closed by a new start code, the unit closed by the
	// buffer end, and the buffer summary.
	always_comb begin
		prev_end = (pos_q >= pos_t'(4)) ? (pos_q - pos_t'(4)) : '0;
		pos_inc = {1'b0, pos_q} + posx_t'(1);
		last_end = (pos_inc > {1'b0, POS_CAP}) ? POS_CAP : pos_inc[POS_W-1:0];

		push.rec[0] = unit_rec(open_off_q, prev_end, units_q - 8'd1, open_type_q, open_first_q);
		push.rec[0].last_result = !last_s1;
		push.rec[1] = unit_rec(open_off_d, last_end, units_d - 8'd1, open_type_d, open_first_d);
		push.rec[1].last_result = !last_s1;

		sum_rec = '0;
		sum_rec.record_kind = REC_SUMMARY;
		sum_rec.unit_count = units_d;
		sum_rec.types_present = seen_d;
		sum_rec.last_result = 1'b1;
		push.rec[2] = sum_rec;

		push.vld[0] = step && take && (units_q != 8'd0);
		push.vld[1] = step && last_s1 && (units_d != 8'd0);
		push.vld[2] = step && last_s1;
	end

	// Scan state; the buffer's last byte clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			recent_q <= '0;
			pending_q <= 1'b0;
			stopped_q <= 1'b0;
			units_q <= '0;
			open_off_q <= '0;
			open_type_q <= UT_UNKNOWN;
			open_first_q <= 1'b0;
			seen_q <= '0;
		end else if (step) begin
			if (last_s1) begin
				pos_q <= '0;
				recent_q <= '0;
				pending_q <= 1'b0;
				stopped_q <= 1'b0;
				units_q <= '0;
				open_off_q <= '0;
				open_type_q <= UT_UNKNOWN;
				open_first_q <= 1'b0;
				seen_q <= '0;
			end else begin
				pos_q <= last_end;
				recent_q <= {recent_q[15:0], byte_s1};
				pending_q <= set_pending;
				stopped_q <= stopped_q || (pending_q && !take);
				units_q <= units_d;
				open_off_q <= open_off_d;
				open_type_q <= open_type_d;
				open_first_q <= open_first_d;
				seen_q <= seen_d;
			end
		end
	end

endmodule

@@ src/anxs_fifo.sv @@
module anxs_fifo
	import anxs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input push_t push,
	input logic pop,
	output rec_t head,
	output logic not_empty,
	output logic [LVL_W-1:0] level
);

	rec_t mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [LVL_W-1:0] level_q;
	logic [PTR_W-1:0] wp1;
	logic [PTR_W-1:0] wp2;
	logic [LVL_W-1:0] n_push;
	logic do_pop;

	// Valid slots go to consecutive entries.
	always_comb begin
		wp1 = wr_q + PTR_W'(push.vld[0]);
		wp2 = wp1 + PTR_W'(push.vld[1]);
		n_push = LVL_W'(push.vld[0]) + LVL_W'(push.vld[1]) + LVL_W'(push.vld[2]);
		do_pop = pop && (level_q != '0);
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push.vld[0]) begin
			mem[wr_q] <= push.rec[0];
		end
		if (push.vld[1]) begin
			mem[wp1] <= push.rec[1];
		end
		if (push.vld[2]) begin
			mem[wp2] <= push.rec[2];
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(n_push);
			rd_q <= rd_q + PTR_W'(do_pop);
			level_q <= level_q + n_push - LVL_W'(do_pop);
		end
	end

	assign head = mem[rd_q];
	assign not_empty = (level_q != '0);
	assign level = level_q;

endmodule

@@ src/annexb_nal_unit_splitter.sv @@
// Annex B start code scanner: one buffer byte per item on the input channel
// (data_byte, last_byte with in_valid / in_stall), result records on the
// output channel (out_valid / out_stall). A record is either a unit record
// (index, type, first-of-type mark, start code offset, both lengths) or the
// buffer summary that follows the buffer's last byte.
// Configuration: cfg_write with cfg_index 0 sets codec_is_h264 from
// cfg_data[0], index 1 sets max_units. Write only while the block is idle.
// Records: a byte's records are written to the result queue when the scan
// stage steps, and the first is offered once stored; further records follow
// one per cycle while out_stall is low, in order.
// Throughput: one byte per clock while the eight-entry result queue holds no
// more than five records; the single scan stage advances only when three
// entries are free. A byte yields up to three records, so a byte that closes
// a buffer or a unit can hold the input until they drain.
// Reset clears the scan state, empties the queue and sets codec_is_h264 to 1
// and max_units to 16. When the receiver stalls, the head record stays on
// the output; the queue fills and then the input stalls too.
`include "annexb_nal_unit_splitter_assert.svh"

module annexb_nal_unit_splitter
	import anxs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_stall,
	output logic record_kind,
	output logic [7:0] unit_index,
	output logic [2:0] unit_type,
	output logic first_of_type,
	output logic [FIELD_W-1:0] start_offset,
	output logic [FIELD_W-1:0] length_with_code,
	output logic [FIELD_W-1:0] length_without_code,
	output logic [7:0] unit_count,
	output logic [4:0] types_present,
	output logic last_result
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic step;
	logic accept;
	push_t push;
	rec_t head;
	logic [LVL_W-1:0] level;

	// The scan stage moves when the queue can take a full burst of results.
	assign step = valid_s1 && (level <= LVL_W'(FIFO_DEPTH - SLOTS));
	assign in_stall = valid_s1 && !step;
	assign accept = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	anxs_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.step(step),
		.byte_s1(byte_s1),
		.last_s1(last_s1),
		.push(push)
	);

	anxs_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(!out_stall),
		.head(head),
		.not_empty(out_valid),
		.level(level)
	);

	assign record_kind = head.record_kind;
	assign unit_index = head.unit_index;
	assign unit_type = head.unit_type;
	assign first_of_type = head.first_of_type;
	assign start_offset = head.start_offset;
	assign length_with_code = head.length_with_code;
	assign length_without_code = head.length_without_code;
	assign unit_count = head.unit_count;
	assign types_present = head.types_present;
	assign last_result = head.last_result;

	// The queue never holds more than its depth.
	`ANXS_ASSERT(a_level_bound, level <= LVL_W'(FIFO_DEPTH), "result queue overflow")
	// A buffer's last byte always closes with a summary record.
	`ANXS_ASSERT(a_summary_push, (step && last_s1) |-> push.vld[2], "missing buffer summary")
	// After a last byte is scanned a record is offered.
	`ANXS_ASSERT(a_out_after_last, (step && last_s1) |=> out_valid, "no record after buffer end")
	// A unit closed by the buffer end is never pushed without its summary.
	`ANXS_NEVER(a_unit_without_sum, push.vld[1] && !push.vld[2], "unit record without summary")

endmodule
